// ----- rtl/sed_pkg.sv -----
// Types and constants shared by the string escape decoder.
// Holds the payload structs, the parse modes, the status codes and the hex digit helper.
// No dependencies.
package sed_pkg;

    localparam int CP_W = 21;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_END_BSLASH  = 4'd1,
        ST_BAD_DQUOTE  = 4'd2,
        ST_BAD_SQUOTE  = 4'd3,
        ST_UNKNOWN_ESC = 4'd4,
        ST_BAD_HEX     = 4'd5,
        ST_INCOMPLETE  = 4'd6,
        ST_UNEXP_LOW   = 4'd7,
        ST_EXPECT_LOW  = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEXHI  = 3'd2,
        MODE_BSLASH = 3'd3,
        MODE_ULOW   = 3'd4,
        MODE_HEXLO  = 3'd5,
        MODE_DROP   = 3'd6
    } mode_t;

    typedef struct packed {
        logic [CP_W-1:0] char_in;
        logic            is_last;
    } sed_in_t;

    typedef struct packed {
        logic [CP_W-1:0] char_out;
        status_t         status;
        logic            end_of_token;
    } sed_out_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] hex_accum;
        logic [1:0]  digit_count;
        logic [9:0]  high_half;
    } sed_state_t;

    // quote kind register codes; any other value allows both quote escapes
    localparam logic [1:0] QK_SINGLE = 2'd0;
    localparam logic [1:0] QK_DOUBLE = 2'd1;
    localparam logic [1:0] QK_RESET  = QK_DOUBLE;

    localparam logic [CP_W-1:0] CH_BSLASH = 21'h00005C;
    localparam logic [CP_W-1:0] CH_DQUOTE = 21'h000022;
    localparam logic [CP_W-1:0] CH_SQUOTE = 21'h000027;
    localparam logic [CP_W-1:0] CH_SLASH  = 21'h00002F;
    localparam logic [CP_W-1:0] CH_B      = 21'h000062;
    localparam logic [CP_W-1:0] CH_F      = 21'h000066;
    localparam logic [CP_W-1:0] CH_N      = 21'h00006E;
    localparam logic [CP_W-1:0] CH_R      = 21'h000072;
    localparam logic [CP_W-1:0] CH_T      = 21'h000074;
    localparam logic [CP_W-1:0] CH_U      = 21'h000075;

    localparam logic [CP_W-1:0] CP_BS     = 21'd8;
    localparam logic [CP_W-1:0] CP_FF     = 21'd12;
    localparam logic [CP_W-1:0] CP_LF     = 21'd10;
    localparam logic [CP_W-1:0] CP_CR     = 21'd13;
    localparam logic [CP_W-1:0] CP_TAB    = 21'd9;

    localparam logic [15:0] HI_SURR_LO = 16'hD800;
    localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LO_SURR_LO = 16'hDC00;
    localparam logic [15:0] LO_SURR_HI = 16'hDFFF;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;

    // Bit 4 set means the code point is no hex digit.
    function automatic logic [4:0] hex_value(input logic [CP_W-1:0] c);
        logic [4:0] v;
        if (c >= 21'h30 && c <= 21'h39) begin
            v = 5'(c - 21'h30);
        end else if (c >= 21'h61 && c <= 21'h66) begin
            v = 5'(c - 21'h61 + 21'd10);
        end else if (c >= 21'h41 && c <= 21'h46) begin
            v = 5'(c - 21'h41 + 21'd10);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

endpackage

// ----- rtl/sed_decode.sv -----
// Next-state and result logic of the string escape decoder, one code point per call.
// Depends on sed_pkg.
module sed_decode (
    input  sed_pkg::sed_state_t state_cur,
    input  sed_pkg::sed_in_t    item,
    input  logic [1:0]          quote_kind,
    output sed_pkg::sed_state_t state_nxt,
    output logic                res_valid,
    output sed_pkg::sed_out_t   res
);

    logic [sed_pkg::CP_W-1:0] c;
    logic                     last;
    logic [4:0]               hv;
    logic [15:0]              acc;
    logic                     do_fail;
    logic                     do_emit;
    sed_pkg::status_t         fail_code;
    logic [sed_pkg::CP_W-1:0] emit_char;

    assign c    = item.char_in;
    assign last = item.is_last;
    assign hv   = sed_pkg::hex_value(c);
    assign acc  = {state_cur.hex_accum[11:0], hv[3:0]};

    always_comb begin
        state_nxt = state_cur;
        do_fail   = 1'b0;
        do_emit   = 1'b0;
        fail_code = sed_pkg::ST_OK;
        emit_char = '0;

        unique case (state_cur.mode)
            sed_pkg::MODE_IDLE: begin
                if (c != sed_pkg::CH_BSLASH) begin
                    do_emit   = 1'b1;
                    emit_char = c;
                end else if (last) begin
                    do_fail   = 1'b1;
                    fail_code = sed_pkg::ST_END_BSLASH;
                end else begin
                    state_nxt.mode = sed_pkg::MODE_ESC;
                end
            end
            sed_pkg::MODE_ESC: begin
                state_nxt.mode = sed_pkg::MODE_IDLE;
                do_emit        = 1'b1;
                case (c)
                    sed_pkg::CH_DQUOTE: begin
                        emit_char = sed_pkg::CH_DQUOTE;
                        if (quote_kind == sed_pkg::QK_SINGLE) begin
                            do_fail   = 1'b1;
                            fail_code = sed_pkg::ST_BAD_DQUOTE;
                        end
                    end
                    sed_pkg::CH_SQUOTE: begin
                        emit_char = sed_pkg::CH_SQUOTE;
                        if (quote_kind == sed_pkg::QK_DOUBLE) begin
                            do_fail   = 1'b1;
                            fail_code = sed_pkg::ST_BAD_SQUOTE;
                        end
                    end
                    sed_pkg::CH_BSLASH: emit_char = sed_pkg::CH_BSLASH;
                    sed_pkg::CH_SLASH:  emit_char = sed_pkg::CH_SLASH;
                    sed_pkg::CH_B:      emit_char = sed_pkg::CP_BS;
                    sed_pkg::CH_F:      emit_char = sed_pkg::CP_FF;
                    sed_pkg::CH_N:      emit_char = sed_pkg::CP_LF;
                    sed_pkg::CH_R:      emit_char = sed_pkg::CP_CR;
                    sed_pkg::CH_T:      emit_char = sed_pkg::CP_TAB;
                    sed_pkg::CH_U: begin
                        do_emit = 1'b0;
                        if (last) begin
                            do_fail   = 1'b1;
                            fail_code = sed_pkg::ST_INCOMPLETE;
                        end else begin
                            state_nxt.mode        = sed_pkg::MODE_HEXHI;
                            state_nxt.hex_accum   = '0;
                            state_nxt.digit_count = '0;
                        end
                    end
                    default: begin
                        do_fail   = 1'b1;
                        fail_code = sed_pkg::ST_UNKNOWN_ESC;
                    end
                endcase
            end
            sed_pkg::MODE_HEXHI, sed_pkg::MODE_HEXLO: begin
                if (hv[4]) begin
                    do_fail   = 1'b1;
                    fail_code = sed_pkg::ST_BAD_HEX;
                end else begin
                    state_nxt.hex_accum = acc;
                    if (state_cur.digit_count != 2'd3) begin
                        if (last) begin
                            do_fail   = 1'b1;
                            fail_code = sed_pkg::ST_INCOMPLETE;
                        end else begin
                            state_nxt.digit_count = state_cur.digit_count + 2'd1;
                        end
                    end else begin
                        state_nxt.digit_count = '0;
                        if (state_cur.mode == sed_pkg::MODE_HEXLO) begin
                            if (acc < sed_pkg::LO_SURR_LO || acc > sed_pkg::LO_SURR_HI) begin
                                do_fail   = 1'b1;
                                fail_code = sed_pkg::ST_EXPECT_LOW;
                            end else begin
                                do_emit   = 1'b1;
                                emit_char = sed_pkg::SUPP_BASE
                                          + {1'b0, state_cur.high_half, acc[9:0]};
                                state_nxt.mode      = sed_pkg::MODE_IDLE;
                                state_nxt.high_half = '0;
                            end
                        end else if (acc >= sed_pkg::LO_SURR_LO
                                     && acc <= sed_pkg::LO_SURR_HI) begin
                            do_fail   = 1'b1;
                            fail_code = sed_pkg::ST_UNEXP_LOW;
                        end else if (acc >= sed_pkg::HI_SURR_LO
                                     && acc <= sed_pkg::HI_SURR_HI) begin
                            if (last) begin
                                do_fail   = 1'b1;
                                fail_code = sed_pkg::ST_INCOMPLETE;
                            end else begin
                                state_nxt.high_half = acc[9:0];
                                state_nxt.mode      = sed_pkg::MODE_BSLASH;
                            end
                        end else begin
                            do_emit        = 1'b1;
                            emit_char      = {5'd0, acc};
                            state_nxt.mode = sed_pkg::MODE_IDLE;
                        end
                    end
                end
            end
            sed_pkg::MODE_BSLASH: begin
                if (c != sed_pkg::CH_BSLASH) begin
                    do_fail   = 1'b1;
                    fail_code = sed_pkg::ST_EXPECT_LOW;
                end else if (last) begin
                    do_fail   = 1'b1;
                    fail_code = sed_pkg::ST_INCOMPLETE;
                end else begin
                    state_nxt.mode = sed_pkg::MODE_ULOW;
                end
            end
            sed_pkg::MODE_ULOW: begin
                if (c != sed_pkg::CH_U) begin
                    do_fail   = 1'b1;
                    fail_code = sed_pkg::ST_EXPECT_LOW;
                end else if (last) begin
                    do_fail   = 1'b1;
                    fail_code = sed_pkg::ST_INCOMPLETE;
                end else begin
                    state_nxt.mode        = sed_pkg::MODE_HEXLO;
                    state_nxt.hex_accum   = '0;
                    state_nxt.digit_count = '0;
                end
            end
            default: begin
                // drop the rest of a failed token
                if (last) begin
                    state_nxt = '0;
                end else begin
                    state_nxt.mode = sed_pkg::MODE_DROP;
                end
            end
        endcase

        res_valid = do_fail | do_emit;
        res       = '0;
        if (do_fail) begin
            state_nxt          = '0;
            state_nxt.mode     = last ? sed_pkg::MODE_IDLE : sed_pkg::MODE_DROP;
            res.status         = fail_code;
            res.end_of_token   = 1'b1;
        end else if (do_emit) begin
            res.char_out     = emit_char;
            res.status       = sed_pkg::ST_OK;
            res.end_of_token = last;
            if (last) begin
                state_nxt = '0;
            end
        end
    end

endmodule

// ----- rtl/string_escape_decoder_unit.sv -----
// Top level of the string escape decoder: input register, decode logic, result register.
// Depends on sed_pkg and sed_decode.
//
// Channel  Dir  Handshake              Word
// s_       in   s_valid / s_ready      sed_in_t  {char_in, is_last}
// m_       out  m_valid / m_ready      sed_out_t {char_out, status, end_of_token}
// cfg_     in   cfg_valid / cfg_ready  quote_kind, 2 bits
//
// One code point per cycle sustained while the result side is not stalled.
// Acceptance loads the input register; its result (if any) then passes into the
// result register once that register is free, and leaves from there.
// The decode step is a single pass of the escape state machine per word.
// Reset (aresetn low at a clock edge) empties both registers, returns the parser
// to idle and sets quote_kind to double-quoted. A stalled result holds its
// register while an empty input register still takes one more word.
module string_escape_decoder_unit (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  sed_pkg::sed_in_t  s_data,

    output logic              m_valid,
    input  logic              m_ready,
    output sed_pkg::sed_out_t m_data,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data
);

    logic                in_valid_reg, in_valid_next;
    sed_pkg::sed_in_t    in_reg;
    logic                out_valid_reg, out_valid_next;
    sed_pkg::sed_out_t   out_reg;
    sed_pkg::sed_state_t state_reg, state_next;
    logic [1:0]          quote_kind_reg;

    logic                advance;
    logic                res_valid;
    sed_pkg::sed_out_t   res;

    // The result register is free when empty or being drained this cycle.
    assign advance   = !out_valid_reg || m_ready;
    // Take a new word when the input register is empty or moves on now.
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    sed_decode u_decode (
        .state_cur  (state_reg),
        .item       (in_reg),
        .quote_kind (quote_kind_reg),
        .state_nxt  (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb begin
        // Hold the input word until the decoder consumes it.
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        // A consumed word may produce no result; the register then goes empty.
        if (advance) begin
            out_valid_next = in_valid_reg && res_valid;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
            quote_kind_reg <= sed_pkg::QK_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // Advance the escape state only when a word is actually consumed.
            if (advance && in_valid_reg) begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready) begin
                quote_kind_reg <= cfg_data;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance && in_valid_reg && res_valid) begin
            out_reg <= res;
        end
    end

    // An error result carries a zero code point and closes the token.
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != sed_pkg::ST_OK)
            |-> (m_data.char_out == '0 && m_data.end_of_token))
        else $error("error result with nonzero code point or open token");

    // Words consumed while dropping a failed token never produce a result.
    a_drop_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && state_reg.mode == sed_pkg::MODE_DROP)
            |=> !out_valid_reg)
        else $error("result produced while dropping a token");

    // A waiting input word is never overwritten while the result side stalls.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
        else $error("input register lost a word during a stall");

    // Parser state only moves when a word is consumed.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_valid_reg) |=> $stable(state_reg))
        else $error("parser state changed without a consumed word");

endmodule

// ----- sim/sed_result_checker.sv -----
// Result checker for the string escape decoder: watches all three channels,
// predicts each decoded word and compares it with what leaves the m_ channel.
// Depends on sed_pkg for the payload structs, parse modes and status codes.
module sed_result_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  sed_pkg::sed_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  sed_pkg::sed_out_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_data,
    output int                mismatch_count,
    output int                expected_left,
    output int                results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted decoder state
    sed_pkg::mode_t pmode;
    logic [15:0]    acc;
    logic [1:0]     ndig;
    logic [9:0]     hi10;
    logic [1:0]     qkind;

    bit                pred_valid;
    sed_pkg::sed_out_t pred_word;
    sed_pkg::sed_out_t decoded_q[$];

    function automatic logic [4:0] digit_value(input logic [sed_pkg::CP_W-1:0] c);
        if (c >= 21'h30 && c <= 21'h39) return {1'b0, c[3:0]};
        if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66))
            return {1'b0, c[3:0] + 4'd9};
        return 5'b10000;
    endfunction

    task automatic clear_parse();
        pmode = sed_pkg::MODE_IDLE;
        acc   = '0;
        ndig  = '0;
        hi10  = '0;
    endtask

    task automatic emit_char(input logic [sed_pkg::CP_W-1:0] cp, input logic last);
        pred_valid             = 1'b1;
        pred_word.char_out     = cp;
        pred_word.status       = sed_pkg::ST_OK;
        pred_word.end_of_token = last;
        if (last) clear_parse();
    endtask

    // an error closes the token's output; the rest of the token is dropped
    task automatic reject_token(input sed_pkg::status_t st, input logic last);
        pred_valid             = 1'b1;
        pred_word.char_out     = '0;
        pred_word.status       = st;
        pred_word.end_of_token = 1'b1;
        clear_parse();
        if (!last) pmode = sed_pkg::MODE_DROP;
    endtask

    task automatic decode_word(input sed_pkg::sed_in_t w);
        logic [sed_pkg::CP_W-1:0] c;
        logic                     last;
        logic [4:0]               hv;
        c = w.char_in;
        last = w.is_last;
        pred_valid = 1'b0;
        pred_word = '0;
        case (pmode)
            sed_pkg::MODE_IDLE: begin
                if (c != sed_pkg::CH_BSLASH) emit_char(c, last);
                else if (last) reject_token(sed_pkg::ST_END_BSLASH, 1'b1);
                else pmode = sed_pkg::MODE_ESC;
            end
            sed_pkg::MODE_ESC: begin
                case (c)
                    sed_pkg::CH_DQUOTE: begin
                        if (qkind == sed_pkg::QK_SINGLE)
                            reject_token(sed_pkg::ST_BAD_DQUOTE, last);
                        else begin
                            pmode = sed_pkg::MODE_IDLE;
                            emit_char(sed_pkg::CH_DQUOTE, last);
                        end
                    end
                    sed_pkg::CH_SQUOTE: begin
                        if (qkind == sed_pkg::QK_DOUBLE)
                            reject_token(sed_pkg::ST_BAD_SQUOTE, last);
                        else begin
                            pmode = sed_pkg::MODE_IDLE;
                            emit_char(sed_pkg::CH_SQUOTE, last);
                        end
                    end
                    sed_pkg::CH_BSLASH, sed_pkg::CH_SLASH: begin
                        pmode = sed_pkg::MODE_IDLE;
                        emit_char(c, last);
                    end
                    sed_pkg::CH_B: begin
                        pmode = sed_pkg::MODE_IDLE;
                        emit_char(sed_pkg::CP_BS, last);
                    end
                    sed_pkg::CH_F: begin
                        pmode = sed_pkg::MODE_IDLE;
                        emit_char(sed_pkg::CP_FF, last);
                    end
                    sed_pkg::CH_N: begin
                        pmode = sed_pkg::MODE_IDLE;
                        emit_char(sed_pkg::CP_LF, last);
                    end
                    sed_pkg::CH_R: begin
                        pmode = sed_pkg::MODE_IDLE;
                        emit_char(sed_pkg::CP_CR, last);
                    end
                    sed_pkg::CH_T: begin
                        pmode = sed_pkg::MODE_IDLE;
                        emit_char(sed_pkg::CP_TAB, last);
                    end
                    sed_pkg::CH_U: begin
                        if (last) reject_token(sed_pkg::ST_INCOMPLETE, 1'b1);
                        else begin
                            pmode = sed_pkg::MODE_HEXHI;
                            acc = '0;
                            ndig = '0;
                        end
                    end
                    default: reject_token(sed_pkg::ST_UNKNOWN_ESC, last);
                endcase
            end
            sed_pkg::MODE_HEXHI, sed_pkg::MODE_HEXLO: begin
                hv = digit_value(c);
                if (hv[4]) reject_token(sed_pkg::ST_BAD_HEX, last);
                else begin
                    acc = {acc[11:0], hv[3:0]};
                    if (ndig != 2'd3) begin
                        if (last) reject_token(sed_pkg::ST_INCOMPLETE, 1'b1);
                        else ndig = ndig + 2'd1;
                    end else begin
                        ndig = '0;
                        if (pmode == sed_pkg::MODE_HEXLO) begin
                            if (acc < sed_pkg::LO_SURR_LO || acc > sed_pkg::LO_SURR_HI)
                                reject_token(sed_pkg::ST_EXPECT_LOW, last);
                            else begin
                                pmode = sed_pkg::MODE_IDLE;
                                emit_char(sed_pkg::SUPP_BASE + {1'b0, hi10, acc[9:0]},
                                    last);
                                hi10 = '0;
                            end
                        end else if (acc >= sed_pkg::LO_SURR_LO
                                     && acc <= sed_pkg::LO_SURR_HI) begin
                            reject_token(sed_pkg::ST_UNEXP_LOW, last);
                        end else if (acc >= sed_pkg::HI_SURR_LO
                                     && acc <= sed_pkg::HI_SURR_HI) begin
                            if (last) reject_token(sed_pkg::ST_INCOMPLETE, 1'b1);
                            else begin
                                hi10 = acc[9:0];
                                pmode = sed_pkg::MODE_BSLASH;
                            end
                        end else begin
                            pmode = sed_pkg::MODE_IDLE;
                            emit_char({5'b0, acc}, last);
                        end
                    end
                end
            end
            sed_pkg::MODE_BSLASH: begin
                if (c != sed_pkg::CH_BSLASH) reject_token(sed_pkg::ST_EXPECT_LOW, last);
                else if (last) reject_token(sed_pkg::ST_INCOMPLETE, 1'b1);
                else pmode = sed_pkg::MODE_ULOW;
            end
            sed_pkg::MODE_ULOW: begin
                if (c != sed_pkg::CH_U) reject_token(sed_pkg::ST_EXPECT_LOW, last);
                else if (last) reject_token(sed_pkg::ST_INCOMPLETE, 1'b1);
                else begin
                    pmode = sed_pkg::MODE_HEXLO;
                    acc = '0;
                    ndig = '0;
                end
            end
            default: begin
                if (last) clear_parse();
                else pmode = sed_pkg::MODE_DROP;
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] checker: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        sed_pkg::sed_out_t want;
        if (!aresetn) begin
            clear_parse();
            qkind = sed_pkg::QK_RESET;
            decoded_q.delete();
            mismatch_count  = 0;
            results_checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) qkind = cfg_data;
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word char=%h status=%0d eot=%b",
                        m_data.char_out, m_data.status, m_data.end_of_token));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_data.char_out !== want.char_out || m_data.status !== want.status ||
                            m_data.end_of_token !== want.end_of_token)
                        report_mismatch($sformatf(
                            {"word %0d: got char=%h status=%0d eot=%b, ",
                             "want char=%h status=%0d eot=%b"},
                            results_checked, m_data.char_out, m_data.status,
                            m_data.end_of_token,
                            want.char_out, want.status, want.end_of_token));
                    results_checked++;
                end
            end
            if (s_valid && s_ready) begin
                decode_word(s_data);
                if (pred_valid) decoded_q.push_back(pred_word);
            end
        end
        expected_left <= decoded_q.size();
    end

endmodule

// ----- sim/string_escape_decoder_unit_tb.sv -----
// Testbench top for string_escape_decoder_unit: clock, reset, token stimulus and verdict.
// Depends on sed_pkg, the decoder RTL and sed_result_checker, which does the result checking.
module string_escape_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // quote kinds beyond the two named in the package
    localparam logic [1:0] QK_BOTH  = 2'd2;
    localparam logic [1:0] QK_SPARE = 2'd3;

    localparam int RANDOM_WORDS = 1450;
    localparam int PHASES       = 6;
    localparam int SETTLE       = 8;       // margin for words still in the registers
    localparam int STALL_LEN    = 300;     // long output hold-off, in cycles
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [sed_pkg::CP_W-1:0] CH_X = 21'h78;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    sed_pkg::sed_in_t  s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    sed_pkg::sed_out_t m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_data  = '0;

    int mismatch_count;
    int expected_left;
    int results_checked;

    // shared between the sender and the receiver process
    bit no_idle       = 1'b0;
    int stall_request = 0;

    int words_sent    = 0;
    int tokens_sent   = 0;
    int settings_used = 1;     // the reset value counts as the first

    sed_pkg::sed_in_t tok[$];

    string_escape_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sed_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .expected_left   (expected_left),
        .results_checked (results_checked)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Receiver: drop ready at random, or hold it low for a requested stretch
    // so the block fills up and backs up onto the input.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_request != 0) begin
                hold_left = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    // Watchdog: end the run if it has not finished by the limit.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus helpers

    // Offer one word, idling first at random. Entered at a clock edge; valid is
    // left high after acceptance so back-to-back words never toggle it.
    task automatic send_word(input sed_pkg::sed_in_t w);
        while (!no_idle && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // Mark the final code point, push the token out, and clear the buffer.
    task automatic send_token();
        tok[tok.size() - 1].is_last = 1'b1;
        foreach (tok[i]) send_word(tok[i]);
        tokens_sent++;
        tok.delete();
    endtask

    // Write quote_kind only once the block has gone quiet: hold the input low,
    // wait out every expected word, then cover words still in flight that
    // produce no result.
    task automatic set_quote_kind(input logic [1:0] k);
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic void put(input logic [sed_pkg::CP_W-1:0] c);
        sed_pkg::sed_in_t w;
        w.char_in = c;
        w.is_last = 1'b0;
        tok.push_back(w);
    endfunction

    function automatic logic [sed_pkg::CP_W-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 21'h30 + v;
        return ($urandom_range(0, 1) ? 21'h61 : 21'h41) + v - 21'd10;
    endfunction

    function automatic void put_u(input logic [15:0] v);
        put(sed_pkg::CH_BSLASH);
        put(sed_pkg::CH_U);
        for (int i = 3; i >= 0; i--) put(hex_char(v[i*4 +: 4]));
    endfunction

    // Bias toward the ends of the 10-bit surrogate payload.
    function automatic logic [9:0] ten_bits();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 10'h000;
        if (pick == 1) return 10'h3FF;
        return 10'($urandom);
    endfunction

    function automatic logic [sed_pkg::CP_W-1:0] plain_char();
        logic [sed_pkg::CP_W-1:0] c;
        int pick;
        pick = $urandom_range(0, 99);
        do begin
            if (pick < 65) c = 21'($urandom_range(32, 126));
            else if (pick < 85) c = 21'($urandom_range(0, 16'hFFFF));
            else if (pick < 95) c = 21'($urandom_range(0, 21'h10FFFF));
            else c = (pick < 97) ? 21'h0 : 21'h10FFFF;
        end while (c == sed_pkg::CH_BSLASH);
        return c;
    endfunction

    function automatic logic [sed_pkg::CP_W-1:0] escape_letter();
        case ($urandom_range(0, 8))
            0: return sed_pkg::CH_DQUOTE;
            1: return sed_pkg::CH_SQUOTE;
            2: return sed_pkg::CH_BSLASH;
            3: return sed_pkg::CH_SLASH;
            4: return sed_pkg::CH_B;
            5: return sed_pkg::CH_F;
            6: return sed_pkg::CH_N;
            7: return sed_pkg::CH_R;
            default: return sed_pkg::CH_T;
        endcase
    endfunction

    // Characters just outside the hex digit ranges, plus a few far away.
    function automatic logic [sed_pkg::CP_W-1:0] not_hex();
        case ($urandom_range(0, 8))
            0: return 21'h2F;      // just below '0'
            1: return 21'h3A;      // just above '9'
            2: return 21'h40;      // just below 'A'
            3: return 21'h47;      // just above 'F'
            4: return 21'h60;      // just below 'a'
            5: return 21'h67;      // just above 'f'
            6: return sed_pkg::CH_BSLASH;
            7: return 21'h1F600;
            default: return CH_X;
        endcase
    endfunction

    function automatic logic [sed_pkg::CP_W-1:0] not_escape();
        case ($urandom_range(0, 6))
            0: return 21'h61;      // 'a'
            1: return CH_X;
            2: return 21'h30;
            3: return 21'h55;      // 'U'
            4: return 21'h4E;      // 'N'
            5: return 21'h10FFFF;
            default: return 21'h20;
        endcase
    endfunction

    function automatic logic [15:0] high_half();
        return sed_pkg::HI_SURR_LO | {6'b0, ten_bits()};
    endfunction

    function automatic void add_good();
        int pick;
        logic [15:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            put(plain_char());
        end else if (pick < 70) begin
            put(sed_pkg::CH_BSLASH);
            put(escape_letter());
        end else if (pick < 88) begin
            if (pick < 72) v = (pick == 70) ? 16'h0000 : 16'hFFFF;
            else do v = 16'($urandom);
                while (v >= sed_pkg::HI_SURR_LO && v <= sed_pkg::LO_SURR_HI);
            put_u(v);
        end else begin
            put_u(high_half());
            put_u(sed_pkg::LO_SURR_LO | {6'b0, ten_bits()});
        end
    endfunction

    // Broken escapes; stop is set where the token must end right here.
    function automatic void add_broken(output bit stop);
        logic [15:0] v;
        int k;
        stop = 1'b0;
        case ($urandom_range(0, 7))
            0: begin
                put(sed_pkg::CH_BSLASH);
                put(not_escape());
            end
            1: begin
                // bad digit in the high half or, after a good high half, the low one
                if ($urandom_range(0, 1)) begin
                    put_u(high_half());
                    put(sed_pkg::CH_BSLASH);
                    put(sed_pkg::CH_U);
                    put(hex_char(4'hD));
                end else begin
                    put(sed_pkg::CH_BSLASH);
                    put(sed_pkg::CH_U);
                end
                k = $urandom_range(0, 2);
                repeat (k) put(hex_char(4'($urandom)));
                put(not_hex());
            end
            2: put_u(sed_pkg::LO_SURR_LO | {6'b0, ten_bits()});
            3: begin
                put_u(high_half());
                case ($urandom_range(0, 2))
                    0: put(CH_X);
                    1: begin
                        put(sed_pkg::CH_BSLASH);
                        put($urandom_range(0, 1) ? CH_X : sed_pkg::CH_N);
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: v = 16'hDBFF;
                            1: v = 16'hE000;
                            2: v = 16'h0041;
                            default: v = 16'hD7FF;
                        endcase
                        put_u(v);
                    end
                endcase
            end
            4: begin
                put(sed_pkg::CH_BSLASH);
                put(sed_pkg::CH_U);
                k = $urandom_range(0, 3);
                repeat (k) put(hex_char(4'($urandom)));
                stop = 1'b1;
            end
            5: begin
                put(sed_pkg::CH_BSLASH);
                stop = 1'b1;
            end
            6: begin
                // token ends somewhere inside a surrogate pair
                put_u(high_half());
                k = $urandom_range(0, 5);
                if (k >= 1) put(sed_pkg::CH_BSLASH);
                if (k >= 2) put(sed_pkg::CH_U);
                if (k >= 3) put(hex_char(4'hD));
                if (k >= 4) put(hex_char(4'hC));
                if (k >= 5) put(hex_char(4'($urandom)));
                stop = 1'b1;
            end
            default: begin
                k = $urandom_range(1, 4);
                repeat (k) begin
                    case ($urandom_range(0, 3))
                        0: put(sed_pkg::CH_BSLASH);
                        1: put(sed_pkg::CH_U);
                        2: put(hex_char(4'($urandom)));
                        default: put(plain_char());
                    endcase
                end
            end
        endcase
    endfunction

    // Mostly well-formed escapes with random content, some broken ones mixed in.
    function automatic void build_token();
        int n;
        bit stop;
        n = $urandom_range(1, 6);
        stop = 1'b0;
        for (int i = 0; i < n && !stop; i++) begin
            if ($urandom_range(0, 99) < 78) add_good();
            else add_broken(stop);
        end
    endfunction

    function automatic logic [1:0] phase_kind(input int ph);
        case (ph)
            0: return QK_BOTH;
            1: return sed_pkg::QK_SINGLE;
            2: return QK_SPARE;
            3: return sed_pkg::QK_DOUBLE;
            4: return sed_pkg::QK_SINGLE;
            default: return QK_BOTH;
        endcase
    endfunction

    // ---------------------------------------------------------------- main sequence

    initial begin
        int phase_end;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed tokens under the reset quote kind (double-quoted).
        // Extremes of the code point range.
        put(21'h000000); put(21'h10FFFF);
        send_token();
        // Allowed quote escape, then a newline escape.
        put(sed_pkg::CH_BSLASH); put(sed_pkg::CH_DQUOTE);
        put(sed_pkg::CH_BSLASH); put(sed_pkg::CH_N);
        send_token();
        // Refused single quote; the trailing character is dropped.
        put(sed_pkg::CH_BSLASH); put(sed_pkg::CH_SQUOTE); put(CH_X);
        send_token();
        // Backslash as the final code point.
        put(sed_pkg::CH_BSLASH);
        send_token();
        // Surrogate pair combined into U+1F600.
        put_u(16'hD83D); put_u(16'hDE00);
        send_token();
        // Unknown escape letter.
        put(sed_pkg::CH_BSLASH); put(21'h71);
        send_token();

        // Random phases, one quote kind each; each write waits for a drained block.
        for (int ph = 0; ph < PHASES; ph++) begin
            set_quote_kind(phase_kind(ph));
            no_idle = (ph == 2);
            if (ph == 3) stall_request = STALL_LEN;
            phase_end = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < phase_end) begin
                build_token();
                send_token();
            end
        end

        // Drain: drop valid, wait for every expected word, then cover late strays.
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d words in %0d tokens under %0d quote settings; %0d results checked.",
            words_sent, tokens_sent, settings_used, results_checked);
        if (mismatch_count == 0 && expected_left == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results still expected.", mismatch_count, expected_left);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- string_escape_decoder_unit.f -----
rtl/sed_pkg.sv
rtl/sed_decode.sv
rtl/string_escape_decoder_unit.sv
sim/sed_result_checker.sv
sim/string_escape_decoder_unit_tb.sv
